// ===== rtl/bpt_pkg.sv =====
// ----------------------------------------------------------------------------
// bpt_pkg
// Shared widths, scaling shifts, register indexes and the coefficient bundle
// for the barometric pressure and temperature compensation pipeline.
// ----------------------------------------------------------------------------
package bpt_pkg;

  // Field widths
  localparam int RAW_W     = 24;
  localparam int COEF_W    = 16;
  localparam int TEMP_W    = 19;
  localparam int PRES_W    = 22;
  localparam int CFG_IDX_W = 3;

  // Internal datapath widths
  localparam int DT_W      = RAW_W + 1;        // raw temp minus scaled reference
  localparam int TC_PROD_W = COEF_W + 1 + DT_W; // coefficient times deviation
  localparam int OFF_W     = 35;
  localparam int SENS_W    = 34;
  localparam int SENS_LO_W = 17;
  localparam int SENS_HI_W = SENS_W - SENS_LO_W;
  localparam int PP_LO_W   = RAW_W + SENS_LO_W;
  localparam int PP_HI_W   = RAW_W + 1 + SENS_HI_W;
  localparam int PROD_W    = 59;
  localparam int DIFF_W    = 39;

  // Scaling
  localparam int TEMP_BASE      = 2000;
  localparam int REF_TEMP_SHIFT = 8;
  localparam int OFF_C_SHIFT    = 16;
  localparam int OFF_TC_SHIFT   = 7;
  localparam int SENS_C_SHIFT   = 15;
  localparam int SENS_TC_SHIFT  = 8;
  localparam int TEMP_DIV_SHIFT = 23;
  localparam int TEMP_RND       = 2 ** TEMP_DIV_SHIFT - 1;
  localparam int P_MUL_SHIFT    = 21;
  localparam int P_OUT_SHIFT    = 15;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENS      = 3'd0,
    REG_OFFSET    = 3'd1,
    REG_SENS_TC   = 3'd2,
    REG_OFFSET_TC = 3'd3,
    REG_REF_TEMP  = 3'd4,
    REG_TEMP_SENS = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [COEF_W-1:0] sens;
    logic [COEF_W-1:0] offset;
    logic [COEF_W-1:0] sens_tc;
    logic [COEF_W-1:0] offset_tc;
    logic [COEF_W-1:0] ref_temp;
    logic [COEF_W-1:0] temp_sens;
  } coef_t;

endpackage

// ===== rtl/bpt_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bpt_cfg_regs
// Calibration word registers, written one beat at a time by index.
// ----------------------------------------------------------------------------
module bpt_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bpt_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bpt_pkg::COEF_W-1:0]       cfg_data_i,
  output bpt_pkg::coef_t                   coef_o
);

  bpt_pkg::coef_t coef_q;

  assign cfg_ready_o = 1'b1;
  assign coef_o      = coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (cfg_valid_i) begin
      case (bpt_pkg::cfg_reg_e'(cfg_index_i))
        bpt_pkg::REG_SENS:      coef_q.sens      <= cfg_data_i;
        bpt_pkg::REG_OFFSET:    coef_q.offset    <= cfg_data_i;
        bpt_pkg::REG_SENS_TC:   coef_q.sens_tc   <= cfg_data_i;
        bpt_pkg::REG_OFFSET_TC: coef_q.offset_tc <= cfg_data_i;
        bpt_pkg::REG_REF_TEMP:  coef_q.ref_temp  <= cfg_data_i;
        bpt_pkg::REG_TEMP_SENS: coef_q.temp_sens <= cfg_data_i;
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

endmodule

// ===== rtl/bpt_coef_stage.sv =====
// ----------------------------------------------------------------------------
// bpt_coef_stage
// Stages 1 to 3: temperature deviation, the three coefficient products, and
// offset, sensitivity and compensated temperature.
// ----------------------------------------------------------------------------
module bpt_coef_stage (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bpt_pkg::coef_t                      coef_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [bpt_pkg::RAW_W-1:0]           raw_pressure_i,
  input  logic [bpt_pkg::RAW_W-1:0]           raw_temperature_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [bpt_pkg::RAW_W-1:0]           d1_o,
  output logic signed [bpt_pkg::OFF_W-1:0]    off_o,
  output logic signed [bpt_pkg::SENS_W-1:0]   sens_o,
  output logic signed [bpt_pkg::TEMP_W-1:0]   temp_o
);

  logic rdy1, rdy2, rdy3;
  logic v1_q, v2_q, v3_q;

  // stage 1
  logic [bpt_pkg::RAW_W-1:0]         d1_1_q;
  logic signed [bpt_pkg::DT_W-1:0]   dt_d, dt_q;
  // stage 2
  logic [bpt_pkg::RAW_W-1:0]            d1_2_q;
  logic signed [bpt_pkg::COEF_W:0]      c_off_tc, c_sens_tc, c_temp_sens;
  logic signed [bpt_pkg::TC_PROD_W-1:0] off_prod_d, sens_prod_d, temp_prod_d;
  logic signed [bpt_pkg::TC_PROD_W-1:0] off_prod_q, sens_prod_q, temp_prod_q;
  // stage 3
  logic [bpt_pkg::RAW_W-1:0]            d1_3_q;
  logic signed [bpt_pkg::TC_PROD_W-1:0] off_shift, sens_shift, temp_adj, temp_shift;
  logic signed [bpt_pkg::OFF_W-1:0]     off_base, off_tc, off_d, off_q;
  logic signed [bpt_pkg::SENS_W-1:0]    sens_base, sens_tc, sens_d, sens_q;
  logic signed [bpt_pkg::TEMP_W-1:0]    temp_d, temp_q;

  // a stage takes a new beat when it is empty or its contents move on
  assign rdy3       = ~v3_q | out_ready_i;
  assign rdy2       = ~v2_q | rdy3;
  assign rdy1       = ~v1_q | rdy2;
  assign in_ready_o = rdy1;

  assign dt_d = $signed({1'b0, raw_temperature_i})
              - $signed({1'b0, coef_i.ref_temp, bpt_pkg::REF_TEMP_SHIFT'(0)});

  assign c_off_tc    = $signed({1'b0, coef_i.offset_tc});
  assign c_sens_tc   = $signed({1'b0, coef_i.sens_tc});
  assign c_temp_sens = $signed({1'b0, coef_i.temp_sens});
  assign off_prod_d  = c_off_tc * dt_q;
  assign sens_prod_d = c_sens_tc * dt_q;
  assign temp_prod_d = c_temp_sens * dt_q;

  always_comb begin
    off_shift  = off_prod_q >>> bpt_pkg::OFF_TC_SHIFT;
    sens_shift = sens_prod_q >>> bpt_pkg::SENS_TC_SHIFT;
    off_base   = bpt_pkg::OFF_W'({coef_i.offset, bpt_pkg::OFF_C_SHIFT'(0)});
    sens_base  = bpt_pkg::SENS_W'({coef_i.sens, bpt_pkg::SENS_C_SHIFT'(0)});
    off_tc     = bpt_pkg::OFF_W'(off_shift);
    sens_tc    = bpt_pkg::SENS_W'(sens_shift);
    off_d      = off_base + off_tc;
    sens_d     = sens_base + sens_tc;
    // bias negative products so the shift rounds toward zero
    temp_adj   = temp_prod_q[bpt_pkg::TC_PROD_W-1]
               ? temp_prod_q + bpt_pkg::TC_PROD_W'(bpt_pkg::TEMP_RND)
               : temp_prod_q;
    temp_shift = temp_adj >>> bpt_pkg::TEMP_DIV_SHIFT;
    temp_d     = bpt_pkg::TEMP_W'(temp_shift) + bpt_pkg::TEMP_W'(bpt_pkg::TEMP_BASE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      d1_1_q <= raw_pressure_i;
      dt_q   <= dt_d;
    end
    if (rdy2) begin
      d1_2_q      <= d1_1_q;
      off_prod_q  <= off_prod_d;
      sens_prod_q <= sens_prod_d;
      temp_prod_q <= temp_prod_d;
    end
    if (rdy3) begin
      d1_3_q <= d1_2_q;
      off_q  <= off_d;
      sens_q <= sens_d;
      temp_q <= temp_d;
    end
  end

  assign out_valid_o = v3_q;
  assign d1_o        = d1_3_q;
  assign off_o       = off_q;
  assign sens_o      = sens_q;
  assign temp_o      = temp_q;

endmodule

// ===== rtl/bpt_press_stage.sv =====
// ----------------------------------------------------------------------------
// bpt_press_stage
// Stages 4 to 6: raw pressure times sensitivity as two partial products,
// their sum, then scale, offset removal and the output register.
// ----------------------------------------------------------------------------
module bpt_press_stage (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [bpt_pkg::RAW_W-1:0]           d1_i,
  input  logic signed [bpt_pkg::OFF_W-1:0]    off_i,
  input  logic signed [bpt_pkg::SENS_W-1:0]   sens_i,
  input  logic signed [bpt_pkg::TEMP_W-1:0]   temp_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [bpt_pkg::TEMP_W-1:0]   temperature_centi_o,
  output logic signed [bpt_pkg::PRES_W-1:0]   pressure_centi_o
);

  logic rdy4, rdy5, rdy6;
  logic v4_q, v5_q, v6_q;

  // stage 4
  logic [bpt_pkg::SENS_LO_W-1:0]          sens_lo;
  logic signed [bpt_pkg::SENS_HI_W-1:0]   sens_hi;
  logic [bpt_pkg::PP_LO_W-1:0]            pp_lo_d, pp_lo_q;
  logic signed [bpt_pkg::PP_HI_W-1:0]     pp_hi_d, pp_hi_q;
  logic signed [bpt_pkg::OFF_W-1:0]       off_4_q, off_5_q;
  logic signed [bpt_pkg::TEMP_W-1:0]      temp_4_q, temp_5_q, temp_6_q;
  // stage 5
  logic signed [bpt_pkg::PROD_W-1:0]      hi_ext, lo_ext, prod_d, prod_q;
  // stage 6
  logic signed [bpt_pkg::PROD_W-1:0]      scaled;
  logic signed [bpt_pkg::DIFF_W-1:0]      diff, pres_full;
  logic signed [bpt_pkg::PRES_W-1:0]      pres_d, pres_q;

  assign rdy6       = ~v6_q | out_ready_i;
  assign rdy5       = ~v5_q | rdy6;
  assign rdy4       = ~v4_q | rdy5;
  assign in_ready_o = rdy4;

  assign sens_lo = sens_i[bpt_pkg::SENS_LO_W-1:0];
  assign sens_hi = $signed(sens_i[bpt_pkg::SENS_W-1:bpt_pkg::SENS_LO_W]);
  assign pp_lo_d = d1_i * sens_lo;
  assign pp_hi_d = $signed({1'b0, d1_i}) * sens_hi;

  always_comb begin
    hi_ext    = bpt_pkg::PROD_W'(pp_hi_q);
    lo_ext    = $signed(bpt_pkg::PROD_W'(pp_lo_q));
    prod_d    = (hi_ext <<< bpt_pkg::SENS_LO_W) + lo_ext;
    scaled    = prod_q >>> bpt_pkg::P_MUL_SHIFT;
    diff      = bpt_pkg::DIFF_W'(scaled) - bpt_pkg::DIFF_W'(off_5_q);
    pres_full = diff >>> bpt_pkg::P_OUT_SHIFT;
    pres_d    = bpt_pkg::PRES_W'(pres_full);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (rdy4) v4_q <= in_valid_i;
      if (rdy5) v5_q <= v4_q;
      if (rdy6) v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      pp_lo_q  <= pp_lo_d;
      pp_hi_q  <= pp_hi_d;
      off_4_q  <= off_i;
      temp_4_q <= temp_i;
    end
    if (rdy5) begin
      prod_q   <= prod_d;
      off_5_q  <= off_4_q;
      temp_5_q <= temp_4_q;
    end
    if (rdy6) begin
      pres_q   <= pres_d;
      temp_6_q <= temp_5_q;
    end
  end

  assign out_valid_o         = v6_q;
  assign temperature_centi_o = temp_6_q;
  assign pressure_centi_o    = pres_q;

endmodule

// ===== rtl/baro_pressure_temp_compensation.sv =====
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation
// First-order compensation of a raw pressure and temperature conversion pair.
//
// Usage:
//   - Load the six calibration words through the cfg channel (index 0..5:
//     sens, offset, sens_tc, offset_tc, ref_temp, temp_sens) while the block
//     is idle. cfg_ready_o is always high; indexes 6 and 7 are ignored.
//   - Send one raw pressure / raw temperature pair per beat on the in
//     channel. Each beat yields exactly one result beat on the out channel:
//     temperature in 0.01 degC and pressure in 0.01 mbar, two's complement.
//   - The pipe has six register stages and takes one beat per cycle while
//     the receiver does not stall (raw pressure times sensitivity is split
//     into two partial products).
//   - When the receiver stalls, the result holds in the output register and
//     each upstream stage keeps taking beats until it is full; in_ready_o
//     falls only once the whole pipe is backed up. Nothing is dropped.
//   - Reset clears all stage valids and sets every calibration word to zero.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bpt_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [bpt_pkg::COEF_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [bpt_pkg::RAW_W-1:0]           raw_pressure_i,
  input  logic [bpt_pkg::RAW_W-1:0]           raw_temperature_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [bpt_pkg::TEMP_W-1:0]   temperature_centi_o,
  output logic signed [bpt_pkg::PRES_W-1:0]   pressure_centi_o
);

  bpt_pkg::coef_t                      coef;
  logic                                mid_valid;
  logic                                mid_ready;
  logic [bpt_pkg::RAW_W-1:0]           mid_d1;
  logic signed [bpt_pkg::OFF_W-1:0]    mid_off;
  logic signed [bpt_pkg::SENS_W-1:0]   mid_sens;
  logic signed [bpt_pkg::TEMP_W-1:0]   mid_temp;

  // calibration words; the user must keep them static while beats are in flight, the block does not enforce it
  bpt_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .coef_o      (coef)
  );

  // deviation, coefficient products, offset / sensitivity / temperature
  bpt_coef_stage u_coef (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .coef_i            (coef),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .raw_pressure_i    (raw_pressure_i),
    .raw_temperature_i (raw_temperature_i),
    .out_valid_o       (mid_valid),
    .out_ready_i       (mid_ready),
    .d1_o              (mid_d1),
    .off_o             (mid_off),
    .sens_o            (mid_sens),
    .temp_o            (mid_temp)
  );

  // pressure product, scaling and the output register
  bpt_press_stage u_press (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (mid_valid),
    .in_ready_o          (mid_ready),
    .d1_i                (mid_d1),
    .off_i               (mid_off),
    .sens_i              (mid_sens),
    .temp_i              (mid_temp),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .temperature_centi_o (temperature_centi_o),
    .pressure_centi_o    (pressure_centi_o)
  );

endmodule

// ===== rtl/bpt_checker.sv =====
// ----------------------------------------------------------------------------
// bpt_checker
// Port-level checks for the compensation pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module bpt_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_ready_o,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [bpt_pkg::TEMP_W-1:0]    temperature_centi_o,
  input logic [bpt_pkg::PRES_W-1:0]    pressure_centi_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(temperature_centi_o)
      && $stable(pressure_centi_o))
    else $error("result beat changed while stalled");

  // with the receiver ready, every stage drains, so the input side is open
  a_in_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input blocked while receiver is ready");

  // the configuration port never backs up
  a_cfg_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration port not ready");

  // an accepted beat reaches the output when the receiver stays ready and reset stays released
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(in_valid_i && in_ready_o, 6) && $past(rst_ni, 6) && $past(rst_ni, 5)
      && $past(rst_ni, 4) && $past(rst_ni, 3) && $past(rst_ni, 2) && $past(rst_ni, 1)
      && $past(out_ready_i, 5) && $past(out_ready_i, 4) && $past(out_ready_i, 3)
      && $past(out_ready_i, 2) && $past(out_ready_i, 1)
    |-> out_valid_o)
    else $error("result beat missing after pipeline latency");

endmodule

bind baro_pressure_temp_compensation bpt_checker u_bpt_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .cfg_ready_o         (cfg_ready_o),
  .in_valid_i          (in_valid_i),
  .in_ready_o          (in_ready_o),
  .out_valid_o         (out_valid_o),
  .out_ready_i         (out_ready_i),
  .temperature_centi_o (temperature_centi_o),
  .pressure_centi_o    (pressure_centi_o)
);
